// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, switched off while reset is held.
`define ASSERT_CLKD(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/wfg_pkg.sv -----
package wfg_pkg;

    // Number of cores tracked; node ids are exactly wide enough to name them.
    localparam int NODES  = 16;
    localparam int NODE_W = $clog2(NODES);

    // Depth of the command queue between front and back; a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef logic [NODE_W-1:0] node_id_t;
    typedef logic [NODES-1:0]  node_vec_t;

    // Function codes of an input transaction.
    typedef enum logic [1:0] {
        FUNC_ADD_EDGE  = 2'd0,
        FUNC_RELEASE   = 2'd1,
        FUNC_CLEAR_ROW = 2'd2,
        FUNC_CLEAR_ALL = 2'd3
    } func_t;

    // Operations handed from the front to the back after classification.
    typedef enum logic [2:0] {
        OP_ADD_EDGE,
        OP_SELF_WAIT,
        OP_RELEASE,
        OP_CLEAR_ROW,
        OP_CLEAR_ALL
    } op_t;

    // Back-end sequencer states.
    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } back_state_t;

    typedef struct packed {
        logic [1:0] func;
        logic [3:0] waiter_node;
        logic [3:0] owner_node;
        logic [3:0] target_node;
    } wfg_in_t;

    typedef struct packed {
        logic cycle_found;
        logic edge_ignored;
    } wfg_out_t;

    typedef struct packed {
        op_t      op;
        node_id_t waiter;
        node_id_t owner;
        node_id_t target;
    } wfg_cmd_t;

endpackage

// ----- hw/rtl/wfg_front.sv -----
module wfg_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  wfg_pkg::wfg_in_t   s_data,
    output logic               cmd_valid,
    input  logic               cmd_ready,
    output wfg_pkg::wfg_cmd_t  cmd
);
    import wfg_pkg::*;

    wfg_cmd_t            slot_reg [QUEUE_DEPTH];
    wfg_cmd_t            slot_wr_next;
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                push;
    logic                pop;

    // Turn a raw transaction into an operation for the back end.
    function automatic wfg_cmd_t classify(wfg_in_t item);
        wfg_cmd_t c;
        c.waiter = item.waiter_node;
        c.owner  = item.owner_node;
        c.target = item.target_node;
        case (func_t'(item.func))
            FUNC_ADD_EDGE: begin
                if (item.waiter_node == item.owner_node) begin
                    c.op = OP_SELF_WAIT;
                end else begin
                    c.op = OP_ADD_EDGE;
                end
            end
            FUNC_RELEASE:   c.op = OP_RELEASE;
            FUNC_CLEAR_ROW: c.op = OP_CLEAR_ROW;
            FUNC_CLEAR_ALL: c.op = OP_CLEAR_ALL;
            default:        c.op = OP_CLEAR_ALL;
        endcase
        return c;
    endfunction

    // Queue status and handshakes.
    assign s_ready   = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    // Pointer and fill-count updates.
    always_comb begin
        slot_wr_next = classify(s_data);
        wr_ptr_next  = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next  = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next   = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Queue control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= slot_wr_next;
        end
    end

endmodule

// ----- hw/rtl/wfg_back.sv -----
module wfg_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  wfg_pkg::wfg_cmd_t  cmd,
    output logic               m_valid,
    input  logic               m_ready,
    output wfg_pkg::wfg_out_t  m_data
);
    import wfg_pkg::*;

    node_vec_t    wait_reg [NODES];
    node_vec_t    wait_next [NODES];
    node_vec_t    rep_reg [NODES];
    node_vec_t    rep_next [NODES];
    back_state_t  state_reg, state_next;
    node_vec_t    seen_reg, seen_next;
    node_id_t     iter_reg, iter_next;
    node_id_t     cur_waiter_reg, cur_waiter_next;
    node_id_t     cur_owner_reg, cur_owner_next;
    logic         m_valid_reg, m_valid_next;
    wfg_out_t     m_data_reg, m_data_next;
    node_vec_t    reach_vec;
    logic         out_free;
    logic         hit;
    logic         stuck;
    logic         last_iter;

    assign out_free  = !m_valid_reg || m_ready;
    assign cmd_ready = (state_reg == ST_IDLE) && out_free;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // One frontier step: union of the rows of every node seen so far.
    always_comb begin
        reach_vec = '0;
        for (int n = 0; n < NODES; n++) begin
            if (seen_reg[n]) begin
                reach_vec = reach_vec | wait_reg[n];
            end
        end
    end

    assign hit       = reach_vec[cur_waiter_reg];
    assign stuck     = ((reach_vec | seen_reg) == seen_reg);
    assign last_iter = (iter_reg == NODE_W'(NODES - 1));

    // Sequencer: executes one command, iterating the search for new edges.
    always_comb begin
        wait_next       = wait_reg;
        rep_next        = rep_reg;
        state_next      = state_reg;
        seen_next       = seen_reg;
        iter_next       = iter_reg;
        cur_waiter_next = cur_waiter_reg;
        cur_owner_next  = cur_owner_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;

        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid && cmd_ready) begin
                    case (cmd.op)
                        OP_ADD_EDGE: begin
                            wait_next[cmd.waiter][cmd.owner] = 1'b1;
                            if (rep_reg[cmd.waiter][cmd.owner]) begin
                                m_valid_next = 1'b1;
                                m_data_next  = '{cycle_found: 1'b0, edge_ignored: 1'b0};
                            end else begin
                                cur_waiter_next = cmd.waiter;
                                cur_owner_next  = cmd.owner;
                                seen_next       = node_vec_t'(1) << cmd.owner;
                                iter_next       = '0;
                                state_next      = ST_SEARCH;
                            end
                        end
                        OP_SELF_WAIT: begin
                            m_valid_next = 1'b1;
                            m_data_next  = '{cycle_found: 1'b0, edge_ignored: 1'b1};
                        end
                        OP_RELEASE: begin
                            for (int i = 0; i < NODES; i++) begin
                                wait_next[i][cmd.target] = 1'b0;
                            end
                            wait_next[cmd.target] = '0;
                            m_valid_next = 1'b1;
                            m_data_next  = '{cycle_found: 1'b0, edge_ignored: 1'b0};
                        end
                        OP_CLEAR_ROW: begin
                            wait_next[cmd.target] = '0;
                            m_valid_next = 1'b1;
                            m_data_next  = '{cycle_found: 1'b0, edge_ignored: 1'b0};
                        end
                        OP_CLEAR_ALL: begin
                            for (int i = 0; i < NODES; i++) begin
                                wait_next[i] = '0;
                                rep_next[i]  = '0;
                            end
                            m_valid_next = 1'b1;
                            m_data_next  = '{cycle_found: 1'b0, edge_ignored: 1'b0};
                        end
                        default: begin
                            m_valid_next = 1'b1;
                            m_data_next  = '{cycle_found: 1'b0, edge_ignored: 1'b0};
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                if (hit || stuck || last_iter) begin
                    // The outcome is stable while waiting for the output slot.
                    if (out_free) begin
                        if (hit) begin
                            rep_next[cur_waiter_reg][cur_owner_reg] = 1'b1;
                        end
                        m_valid_next = 1'b1;
                        m_data_next  = '{cycle_found: hit, edge_ignored: 1'b0};
                        state_next   = ST_IDLE;
                    end
                end else begin
                    seen_next = seen_reg | reach_vec;
                    iter_next = iter_reg + 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and both matrices clear on reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            wait_reg    <= '{default: '0};
            rep_reg     <= '{default: '0};
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            wait_reg    <= wait_next;
            rep_reg     <= rep_next;
        end
    end

    // Search working registers and result payload.
    always_ff @(posedge aclk) begin
        seen_reg       <= seen_next;
        iter_reg       <= iter_next;
        cur_waiter_reg <= cur_waiter_next;
        cur_owner_reg  <= cur_owner_next;
        m_data_reg     <= m_data_next;
    end

endmodule

// ----- hw/rtl/wait_for_graph_deadlock_detector_unit.sv -----
// Path: a transaction is registered into the front-end queue and its result into the
// back-end output register; an add-edge that needs a reachability search first steps
// through ST_SEARCH until a hit, no new node, or the last iteration.
// Throughput: one frontier step per cycle over the wait matrix; other operations
// sustain one transaction per cycle via a 2-entry queue unless searching or stalled.
// Reset: synchronous, active low; empties the queue and clears both matrices.
module wait_for_graph_deadlock_detector_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  wfg_pkg::wfg_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output wfg_pkg::wfg_out_t  m_data
);
    import wfg_pkg::*;

    logic      cmd_valid;
    logic      cmd_ready;
    wfg_cmd_t  cmd;

    // Front end: accepts and classifies transactions into the queue.
    wfg_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // Back end: owns the matrices, runs the search and holds the result.
    wfg_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ----- hw/rtl/wfg_checker.sv -----
`include "assert_macros.svh"

module wfg_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input wfg_pkg::wfg_in_t   s_data,
    input logic               m_valid,
    input logic               m_ready,
    input wfg_pkg::wfg_out_t  m_data
);

    // A result waiting at the output keeps its value until it is taken.
    `ASSERT_CLKD(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "result transaction changed while stalled")

    // A self-wait never reports a cycle at the same time.
    `ASSERT_CLKD(a_out_exclusive, aclk, aresetn, m_valid |-> !(m_data.cycle_found && m_data.edge_ignored), "cycle_found and edge_ignored both set")

    // Reset leaves no result pending.
    `ASSERT_ALWAYS(a_reset_out, aclk, !aresetn |=> !m_valid, "result valid after reset")

    // Reset leaves the input queue empty and ready.
    `ASSERT_ALWAYS(a_reset_in, aclk, !aresetn |=> s_ready, "input not ready after reset")

endmodule

bind wait_for_graph_deadlock_detector_unit wfg_checker u_wfg_checker (.*);
